// ----- sv/mlmf_pkg.sv -----
package mlmf_pkg;

  // width of the size field in each configuration register
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned MIN_SIZE = 2;

  // register indexes, taken from paddr[2]
  localparam logic [0:0] REG_ROW_COUNT = 1'b0;
  localparam logic [0:0] REG_COL_COUNT = 1'b1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

endpackage

// ----- sv/mlmf_ram.sv -----
module mlmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/matrix_local_minimum_finder.sv -----
// Flow: an item is taken while the result buffer is empty or in the cycle it empties;
// its results are on the output from the next cycle, one per cycle while out_stall is low.
// Throughput: one item per cycle outside the last row while out_stall is low; in the
// last row up to three results per item share the single output port.
// Reset: counters cleared, row_count and col_count set to 2. Line RAMs are not
// cleared and need no clearing pass: no value read before its entry is written is used.
module matrix_local_minimum_finder #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mlmf_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [mlmf_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [mlmf_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DATA_WIDTH-1:0]          pixel_value,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [DATA_WIDTH-1:0]          cell_value,
  output logic [$clog2(MAX_ROWS)-1:0]           cell_row,
  output logic [$clog2(MAX_COLS)-1:0]           cell_col,
  output logic                                  is_minimum,
  output logic                                  last_of_run,
  output logic                                  frame_end
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int RC_W  = $clog2(MAX_ROWS + 1);
  localparam int CC_W  = $clog2(MAX_COLS + 1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [ROW_W-1:0]             row;
    logic [COL_W-1:0]             col;
    logic                         minimum;
    logic                         last;
    logic                         fend;
  } res_t;

  // ---------------------------------------------------------------- config
  logic [RC_W-1:0] rows;
  logic [CC_W-1:0] cols;
  logic            cfg_wr;
  logic [mlmf_pkg::CFG_W-1:0] cfg_val;

  function automatic logic [RC_W-1:0] clamp_rows(input logic [mlmf_pkg::CFG_W-1:0] v);
    if (32'(v) < mlmf_pkg::MIN_SIZE) return RC_W'(mlmf_pkg::MIN_SIZE);
    else if (32'(v) > MAX_ROWS) return RC_W'(MAX_ROWS);
    else return RC_W'(v);
  endfunction

  function automatic logic [CC_W-1:0] clamp_cols(input logic [mlmf_pkg::CFG_W-1:0] v);
    if (32'(v) < mlmf_pkg::MIN_SIZE) return CC_W'(mlmf_pkg::MIN_SIZE);
    else if (32'(v) > MAX_COLS) return CC_W'(MAX_COLS);
    else return CC_W'(v);
  endfunction

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_val = pwdata[mlmf_pkg::CFG_W-1:0];

  always_comb begin
    unique case (paddr[2])
      mlmf_pkg::REG_ROW_COUNT: prdata = mlmf_pkg::APB_DATA_W'(rows);
      mlmf_pkg::REG_COL_COUNT: prdata = mlmf_pkg::APB_DATA_W'(cols);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= RC_W'(mlmf_pkg::MIN_SIZE);
      cols <= CC_W'(mlmf_pkg::MIN_SIZE);
    end else if (cfg_wr) begin
      if (paddr[2] == mlmf_pkg::REG_ROW_COUNT) begin
        rows <= clamp_rows(cfg_val);
      end else begin
        cols <= clamp_cols(cfg_val);
      end
    end
  end

  // ---------------------------------------------------------------- position
  logic [ROW_W-1:0] row_ctr;
  logic [COL_W-1:0] col_ctr;
  logic [CC_W-1:0]  c_inc;
  logic [RC_W-1:0]  r_inc;
  logic             col_wrap;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             in_take;
  logic             out_take;
  logic [1:0]       cnt;

  assign out_take = out_valid & ~out_stall;
  assign in_stall = ~((cnt == 2'd0) | ((cnt == 2'd1) & out_take));
  assign in_take  = in_valid & ~in_stall;

  assign c_inc    = CC_W'(col_ctr) + CC_W'(1);
  assign r_inc    = RC_W'(row_ctr) + RC_W'(1);
  assign col_wrap = (c_inc >= cols);
  assign col_next = col_wrap ? '0 : c_inc[COL_W-1:0];
  assign row_next = !col_wrap ? row_ctr : ((r_inc >= rows) ? '0 : r_inc[ROW_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_ctr <= '0;
      col_ctr <= '0;
    end else if (in_take) begin
      row_ctr <= row_next;
      col_ctr <= col_next;
    end
  end

  // ---------------------------------------------------------------- line RAMs
  // mid RAM is read two columns ahead (m1 = middle[c+1]); upper one column ahead.
  logic signed [DATA_WIDTH-1:0] mid_q, up_q, m1, m0, pm, prev, prev2, first_val, fwd_data;
  logic [COL_W-1:0]             mid_raddr;
  logic                         fwd;

  assign mid_raddr = col_next + COL_W'(1);

  mlmf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_COLS)) u_mid_ram (
    .clk   (clk),
    .we    (in_take),
    .waddr (col_ctr),
    .wdata (pixel_value),
    .re    (in_take),
    .raddr (mid_raddr),
    .rdata (mid_q)
  );

  mlmf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_COLS)) u_up_ram (
    .clk   (clk),
    .we    (in_take),
    .waddr (col_ctr),
    .wdata (m0),
    .re    (in_take),
    .raddr (col_next),
    .rdata (up_q)
  );

  // two-column rows: the look-ahead read hits the entry written in the same cycle
  assign m1 = fwd ? fwd_data : mid_q;

  always_ff @(posedge clk) begin
    if (in_take) begin
      fwd      <= (mid_raddr == col_ctr);
      fwd_data <= pixel_value;
      m0       <= col_wrap ? first_val : m1;
      pm       <= m0;
      prev     <= pixel_value;
      prev2    <= prev;
      if (col_ctr == '0) begin
        first_val <= pixel_value;
      end
    end
  end

  // ---------------------------------------------------------------- verdicts
  logic last_row, has1, has2, has3;
  logic col_first, col_second, col_last;
  res_t r1, r2, r3;
  res_t slot [3];

  assign last_row   = ({1'b0, row_ctr} == RC_W'(rows - RC_W'(1)));
  assign col_first  = (col_ctr == '0);
  assign col_second = (col_ctr == COL_W'(1));
  assign col_last   = col_wrap;
  assign has1       = (row_ctr != '0);
  assign has2       = has1 & last_row & ~col_first;
  assign has3       = has1 & last_row & col_last;

  always_comb begin
    r1.value   = m0;
    r1.row     = row_ctr - ROW_W'(1);
    r1.col     = col_ctr;
    r1.minimum = (m0 < pixel_value)
               & ((row_ctr == ROW_W'(1)) | (m0 < up_q))
               & (col_first | (m0 < pm))
               & (col_last | (m0 < m1));
    r1.last    = ~has2;
    r1.fend    = 1'b0;

    r2.value   = prev;
    r2.row     = row_ctr;
    r2.col     = col_ctr - COL_W'(1);
    r2.minimum = (prev < pixel_value) & (prev < pm) & (col_second | (prev < prev2));
    r2.last    = ~has3;
    r2.fend    = 1'b0;

    r3.value   = pixel_value;
    r3.row     = row_ctr;
    r3.col     = col_ctr;
    r3.minimum = (pixel_value < prev) & (pixel_value < m0);
    r3.last    = 1'b1;
    r3.fend    = 1'b1;
  end

  // ---------------------------------------------------------------- result buffer
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      cnt <= 2'd0;
    end else if (in_take) begin
      cnt <= has1 ? (2'd1 + 2'(has2) + 2'(has3)) : 2'd0;
    end else if (out_take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      slot[0] <= r1;
      slot[1] <= r2;
      slot[2] <= r3;
    end else if (out_take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign out_valid   = (cnt != 2'd0);
  assign cell_value  = slot[0].value;
  assign cell_row    = slot[0].row;
  assign cell_col    = slot[0].col;
  assign is_minimum  = slot[0].minimum;
  assign last_of_run = slot[0].last;
  assign frame_end   = slot[0].fend;

  // ---------------------------------------------------------------- checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd0 || !out_valid)
    else $error("result count and valid disagree");

  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_of_run)
    else $error("frame end result not last of run");

  a_row0_quiet: assert property (@(posedge clk) disable iff (rst)
    in_take && row_ctr == '0 |=> cnt == 2'd0)
    else $error("item in first row produced results");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> row_ctr == '0 && col_ctr == '0)
    else $error("configuration write did not restart frame");

endmodule
